// ----- src/hvd_pkg.sv -----
`default_nettype none
package hvd_pkg;

   // Q30 fixed point for angles in radians and for trig values
   localparam int Q = 30;
   localparam logic [30:0] ONE_Q = 31'h4000_0000;
   localparam logic [30:0] HALF_Q = 31'h2000_0000;
   localparam logic [32:0] PI_HALF_Q32 = 33'd6746518852;
   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

   // degrees per turn and twice the earth radius in km
   localparam int DEG_PER_TURN = 360;
   localparam logic [13:0] TWO_RADIUS_KM = 14'd12742;

   localparam logic [22:0] FINE_MAX = 23'h7F_FFFF;
   localparam logic [14:0] MAX_KM = 15'd20015;

   // Taylor divisors for the Horner forms of sin and cos
   localparam int SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
   localparam int COS_DIV [6] = '{182, 132, 90, 56, 30, 12};
   localparam int HORNER_STEPS = 6;

   localparam int SQRT_STEPS = 30;
   localparam int ASIN_TERMS = 24;

   // pipeline depths of the sections
   localparam int BAM_LAT = 5;
   localparam int SC_LAT = 2 + 3 * HORNER_STEPS + 2;
   localparam int MUL_LAT = 3;
   localparam int ASIN_LAT = SQRT_STEPS + 3 * ASIN_TERMS + 2;
   localparam int PIPE_LAT = BAM_LAT + SC_LAT + MUL_LAT + ASIN_LAT + 1;

   // shift for the reciprocal of a constant divisor below 2^31
   function automatic int rdiv_k(input int d);
      return 32 + $clog2(d + 1) - 1;
   endfunction

   // quotient estimate by reciprocal, low by at most one
   function automatic logic [31:0] rdiv_est(input logic [31:0] y, input logic [32:0] m,
                                            input int k);
      logic [64:0] prod;
      prod = 65'(y) * 65'(m);
      return 32'(prod >> k);
   endfunction

   // one compare and subtract fixes the estimate
   function automatic logic [31:0] rdiv_fix(input logic [31:0] y, input logic [31:0] q0,
                                            input int d);
      logic [31:0] r;
      r = y - 32'(q0 * 32'(d));
      return (r >= 32'(d)) ? q0 + 32'd1 : q0;
   endfunction

endpackage
`default_nettype wire

// ----- src/hvd_if.sv -----
`default_nettype none
interface hvd_req_if;
   logic               valid;
   logic               ready;
   logic signed [29:0] lat_a;
   logic signed [30:0] lon_a;
   logic signed [29:0] lat_b;
   logic signed [30:0] lon_b;

   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [22:0] distance_fine;
   logic [14:0] distance_whole_km;

   modport source (output valid, distance_fine, distance_whole_km, input ready);
   modport sink (input valid, distance_fine, distance_whole_km, output ready);
endinterface
`default_nettype wire

// ----- src/hvd_sincos.sv -----
`default_nettype none
module hvd_sincos import hvd_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic [31:0]        bam,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   typedef struct packed {
      logic [30:0] x;
      logic [31:0] x2;
      logic [1:0]  quad;
   } carry_type;

   // quadrant residue to Q30 radians
   logic [30:0] x0_in, x0_ff;
   logic [1:0]  quad0_ff;

   assign x0_in = 31'((64'(bam[29:0]) * 64'(PI_HALF_Q32) + (64'd1 << 31)) >> 32);

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff    <= x0_in;
         quad0_ff <= bam[31:30];
      end
   end

   // square of the angle
   carry_type c1_in, c1_ff;

   always_comb begin
      c1_in.x    = x0_ff;
      c1_in.x2   = 32'((64'(x0_ff) * 64'(x0_ff)) >> Q);
      c1_in.quad = quad0_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) c1_ff <= c1_in;
   end

   // Horner steps, three stages each: multiply, reciprocal, fix up
   carry_type   hc [0:HORNER_STEPS];
   logic [30:0] ts [0:HORNER_STEPS];
   logic [30:0] tc [0:HORNER_STEPS];

   assign hc[0] = c1_ff;
   assign ts[0] = ONE_Q;
   assign tc[0] = ONE_Q;

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      localparam int DS = SIN_DIV[i];
      localparam int DC = COS_DIV[i];
      localparam int KS = rdiv_k(DS);
      localparam int KC = rdiv_k(DC);
      localparam logic [32:0] MS = 33'((65'd1 << KS) / DS);
      localparam logic [32:0] MC = 33'((65'd1 << KC) / DC);

      carry_type   ca_ff, cb_ff, cc_ff;
      logic [31:0] ys_in, yc_in, ys_ff, yc_ff, ysb_ff, ycb_ff;
      logic [31:0] qs0_in, qc0_in, qs0_ff, qc0_ff;
      logic [30:0] tsn_in, tcn_in, tsn_ff, tcn_ff;

      assign ys_in  = 32'((64'(hc[i].x2) * 64'(ts[i])) >> Q);
      assign yc_in  = 32'((64'(hc[i].x2) * 64'(tc[i])) >> Q);
      assign qs0_in = rdiv_est(ys_ff, MS, KS);
      assign qc0_in = rdiv_est(yc_ff, MC, KC);
      assign tsn_in = 31'(32'(ONE_Q) - rdiv_fix(ysb_ff, qs0_ff, DS));
      assign tcn_in = 31'(32'(ONE_Q) - rdiv_fix(ycb_ff, qc0_ff, DC));

      always_ff @(posedge clock) begin
         if (advance) begin
            ca_ff  <= hc[i];
            ys_ff  <= ys_in;
            yc_ff  <= yc_in;
            cb_ff  <= ca_ff;
            ysb_ff <= ys_ff;
            ycb_ff <= yc_ff;
            qs0_ff <= qs0_in;
            qc0_ff <= qc0_in;
            cc_ff  <= cb_ff;
            tsn_ff <= tsn_in;
            tcn_ff <= tcn_in;
         end
      end

      assign hc[i+1] = cc_ff;
      assign ts[i+1] = tsn_ff;
      assign tc[i+1] = tcn_ff;
   end

   // final products
   logic [30:0] s_in, s_ff;
   logic [31:0] yq_in, yq_ff;
   logic [1:0]  quadm_ff;

   assign s_in  = 31'((64'(hc[HORNER_STEPS].x) * 64'(ts[HORNER_STEPS])) >> Q);
   assign yq_in = 32'((64'(hc[HORNER_STEPS].x2) * 64'(tc[HORNER_STEPS])) >> Q);

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff     <= s_in;
         yq_ff    <= yq_in;
         quadm_ff <= hc[HORNER_STEPS].quad;
      end
   end

   // cosine clamp and quadrant unfolding
   logic signed [32:0] c_raw;
   logic signed [31:0] s_pos, c_pos;
   logic signed [31:0] sin_in, cos_in, sin_ff, cos_ff;

   always_comb begin
      c_raw = $signed(33'(ONE_Q)) - $signed(33'(yq_ff >> 1));
      c_pos = c_raw[32] ? 32'sd0 : 32'(c_raw);
      s_pos = $signed({1'b0, s_ff});
      case (quadm_ff)
         2'd0: begin
            sin_in = s_pos;
            cos_in = c_pos;
         end
         2'd1: begin
            sin_in = c_pos;
            cos_in = -s_pos;
         end
         2'd2: begin
            sin_in = -s_pos;
            cos_in = -c_pos;
         end
         default: begin
            sin_in = -c_pos;
            cos_in = s_pos;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
`default_nettype wire

// ----- src/hvd_asin.sv -----
`default_nettype none
module hvd_asin import hvd_pkg::*; (
   input  logic        clock,
   input  logic        advance,
   input  logic [29:0] mag,
   input  logic        hi,
   output logic [30:0] half_angle
);

   typedef struct packed {
      logic [29:0] root;
      logic [59:0] rem;
      logic        hi;
   } sq_type;

   typedef struct packed {
      logic [29:0] p;
      logic [29:0] x2;
      logic [30:0] sum;
      logic        hi;
   } term_type;

   // restoring square root, one result bit a stage
   sq_type sq [0:SQRT_STEPS];

   always_comb begin
      sq[0].root = '0;
      sq[0].rem  = {mag, 30'd0};
      sq[0].hi   = hi;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int K = SQRT_STEPS - 1 - j;
      logic [61:0] trial;
      sq_type      st_in, st_ff;

      always_comb begin
         trial = (62'(sq[j].root) << (K + 1)) + (62'd1 << (2 * K));
         st_in = sq[j];
         if (62'(sq[j].rem) >= trial) begin
            st_in.rem  = 60'(62'(sq[j].rem) - trial);
            st_in.root = sq[j].root | (30'd1 << K);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) st_ff <= st_in;
      end

      assign sq[j+1] = st_ff;
   end

   // square of the arcsine argument
   term_type tm [0:ASIN_TERMS];
   term_type t0_in, t0_ff;

   always_comb begin
      t0_in.p   = sq[SQRT_STEPS].root;
      t0_in.x2  = 30'((60'(sq[SQRT_STEPS].root) * 60'(sq[SQRT_STEPS].root)) >> Q);
      t0_in.sum = '0;
      t0_in.hi  = sq[SQRT_STEPS].hi;
   end

   always_ff @(posedge clock) begin
      if (advance) t0_ff <= t0_in;
   end

   assign tm[0] = t0_ff;

   // series terms: sum += p/(2n+1), p = w - ceil(w/(2n+2)) with w = p*x2
   for (genvar n = 0; n < ASIN_TERMS; n++) begin : g_term
      localparam int DS = 2 * n + 1;
      localparam int DC = 2 * n + 2;
      localparam int KS = rdiv_k(DS);
      localparam int KC = rdiv_k(DC);
      localparam logic [32:0] MS = 33'((65'd1 << KS) / DS);
      localparam logic [32:0] MC = 33'((65'd1 << KC) / DC);

      term_type    ca_ff, cb_in, cb_ff, cc_in, cc_ff;
      logic [29:0] w_in, w_ff, wb_ff;
      logic [31:0] qs0_in, qs0_ff, yc_in, yc_ff, qc0_in, qc0_ff;

      assign w_in   = 30'((60'(tm[n].p) * 60'(tm[n].x2)) >> Q);
      assign qs0_in = rdiv_est(32'(tm[n].p), MS, KS);
      assign yc_in  = 32'(w_ff) + 32'(DC - 1);
      assign qc0_in = rdiv_est(yc_in, MC, KC);

      always_comb begin
         cb_in     = ca_ff;
         cb_in.sum = ca_ff.sum + 31'(rdiv_fix(32'(ca_ff.p), qs0_ff, DS));
         cc_in     = cb_ff;
         cc_in.p   = 30'(32'(wb_ff) - rdiv_fix(yc_ff, qc0_ff, DC));
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            ca_ff  <= tm[n];
            w_ff   <= w_in;
            qs0_ff <= qs0_in;
            cb_ff  <= cb_in;
            wb_ff  <= w_ff;
            yc_ff  <= yc_in;
            qc0_ff <= qc0_in;
            cc_ff  <= cc_in;
         end
      end

      assign tm[n+1] = cc_ff;
   end

   // fold back for arguments above one half
   logic [30:0] h_in, h_ff;

   assign h_in = tm[ASIN_TERMS].hi ? PI_HALF_Q30 - tm[ASIN_TERMS].sum : tm[ASIN_TERMS].sum;

   always_ff @(posedge clock) begin
      if (advance) h_ff <= h_in;
   end

   assign half_angle = h_ff;

endmodule
`default_nettype wire

// ----- src/haversine_distance.sv -----
`default_nettype none
// Great-circle distance between two positions by the haversine formula.
//
// req_ch carries one position pair per transfer: latitudes and longitudes in
// signed fixed-point degrees. rsp_ch returns one result per pair, the
// distance in km with DIST_FRAC_BITS fraction bits and the whole-km floor,
// in the order the pairs arrived.
//
// Throughput: one pair per clock unless the receiver stalls. Every
// operation sits in a fixed pipeline (division by 360 for binary angles,
// Taylor sin/cos, square root and arcsine series, each registered step by
// step), so nothing iterates in place.
//
// Reset clears the valid bits of the pipeline and of the output register;
// data registers are not reset. No state is kept between pairs.
// When the receiver stalls, the result waits in the output register while
// the pipeline keeps moving; req_ch.ready falls only once the last pipeline
// stage also holds a finished item, and then the whole pipeline holds.
module haversine_distance import hvd_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 22,
   parameter int DIST_FRAC_BITS  = 8
) (
   input  logic      clock,
   input  logic      reset,
   hvd_req_if.sink   req_ch,
   hvd_rsp_if.source rsp_ch
);

   localparam int SH_HALF = 31 - ANGLE_FRAC_BITS;
   localparam int SH_FULL = 32 - ANGLE_FRAC_BITS;
   localparam int K360 = rdiv_k(DEG_PER_TURN);
   localparam logic [32:0] M360 = 33'((65'd1 << K360) / DEG_PER_TURN);
   localparam int PROD_W = 45;
   localparam int FINE_W = PROD_W + DIST_FRAC_BITS - Q;

   // magnitude product in Q30, truncated toward zero
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic [31:0] ma, mb, m;
      logic [63:0] p;
      ma = a[31] ? 32'(-a) : 32'(a);
      mb = b[31] ? 32'(-b) : 32'(b);
      p  = 64'(ma) * 64'(mb);
      m  = 32'(p >> Q);
      return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
   endfunction

   // pipeline control: advance unless the last stage is blocked
   logic                adv;
   logic                out_vld_ff;
   logic [PIPE_LAT-1:0] vld_in, vld_ff;

   assign adv          = !vld_ff[PIPE_LAT-1] || !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[PIPE_LAT-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // the four angles: the differences (halved in the binary angle), then both latitudes
   logic signed [32:0] ang [4];

   assign ang[0] = 33'(req_ch.lat_b) - 33'(req_ch.lat_a);
   assign ang[1] = 33'(req_ch.lon_b) - 33'(req_ch.lon_a);
   assign ang[2] = 33'(req_ch.lat_a);
   assign ang[3] = 33'(req_ch.lat_b);

   logic [31:0] bam [4];

   // binary angle: (deg << sh) / 360, split as q*2^sh + (rem << sh) / 360
   for (genvar j = 0; j < 4; j++) begin : g_bam
      localparam int SH = (j < 2) ? SH_HALF : SH_FULL;

      logic        neg0_ff, neg1_ff, neg2_ff, neg3_ff;
      logic [31:0] mag_in, mag0_ff, mag1_ff;
      logic [31:0] q0_in, q0_ff, a_in, a2_ff, a3_ff;
      logic [31:0] y_in, y2_ff, y3_ff, qb_in, qb_ff;
      logic [31:0] pb, bam_in, bam_ff;

      assign mag_in = ang[j][32] ? 32'(-ang[j]) : 32'(ang[j]);
      assign q0_in  = rdiv_est(mag0_ff, M360, K360);
      assign a_in   = rdiv_fix(mag1_ff, q0_ff, DEG_PER_TURN);
      assign y_in   = (mag1_ff - 32'(a_in * 32'(DEG_PER_TURN))) << SH;
      assign qb_in  = rdiv_est(y2_ff, M360, K360);
      assign pb     = (a3_ff << SH) + rdiv_fix(y3_ff, qb_ff, DEG_PER_TURN);
      assign bam_in = neg3_ff ? -pb : pb;

      always_ff @(posedge clock) begin
         if (adv) begin
            neg0_ff <= ang[j][32];
            mag0_ff <= mag_in;
            neg1_ff <= neg0_ff;
            mag1_ff <= mag0_ff;
            q0_ff   <= q0_in;
            neg2_ff <= neg1_ff;
            a2_ff   <= a_in;
            y2_ff   <= y_in;
            neg3_ff <= neg2_ff;
            a3_ff   <= a2_ff;
            y3_ff   <= y2_ff;
            qb_ff   <= qb_in;
            bam_ff  <= bam_in;
         end
      end

      assign bam[j] = bam_ff;
   end

   // sin of the half differences, cos of the latitudes
   logic signed [31:0] u, v, c1, c2;

   hvd_sincos u_sc_dlat (
      .clock   (clock),
      .advance (adv),
      .bam     (bam[0]),
      .sin_out (u),
      .cos_out ()
   );

   hvd_sincos u_sc_dlon (
      .clock   (clock),
      .advance (adv),
      .bam     (bam[1]),
      .sin_out (v),
      .cos_out ()
   );

   hvd_sincos u_sc_lat_a (
      .clock   (clock),
      .advance (adv),
      .bam     (bam[2]),
      .sin_out (),
      .cos_out (c1)
   );

   hvd_sincos u_sc_lat_b (
      .clock   (clock),
      .advance (adv),
      .bam     (bam[3]),
      .sin_out (),
      .cos_out (c2)
   );

   // a = u^2 + c1 c2 v^2, clamped to [0, 1], folded about one half
   logic signed [31:0] uu_ff, uu1_ff, vv_ff, cc_ff, w_in, w_ff;
   logic signed [32:0] a_sum;
   logic [30:0]        a_clip;
   logic               hi_in, hi_ff;
   logic [29:0]        m_in, m_ff;

   assign w_in = mulq(cc_ff, vv_ff);

   always_comb begin
      a_sum = 33'(uu1_ff) + 33'(w_ff);
      if (a_sum[32]) begin
         a_clip = '0;
      end else if (a_sum > $signed(33'(ONE_Q))) begin
         a_clip = ONE_Q;
      end else begin
         a_clip = 31'(a_sum);
      end
      hi_in = a_clip > HALF_Q;
      m_in  = hi_in ? 30'(ONE_Q - a_clip) : 30'(a_clip);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         uu_ff  <= mulq(u, u);
         vv_ff  <= mulq(v, v);
         cc_ff  <= mulq(c1, c2);
         uu1_ff <= uu_ff;
         w_ff   <= w_in;
         m_ff   <= m_in;
         hi_ff  <= hi_in;
      end
   end

   // half angle by square root and arcsine
   logic [30:0] h;

   hvd_asin u_asin (
      .clock      (clock),
      .advance    (adv),
      .mag        (m_ff),
      .hi         (hi_ff),
      .half_angle (h)
   );

   // scale by the diameter
   logic [PROD_W-1:0] prod_in, prod_ff;

   assign prod_in = PROD_W'(h) * PROD_W'(TWO_RADIUS_KM);

   always_ff @(posedge clock) begin
      if (adv) prod_ff <= prod_in;
   end

   // output register: loads when empty or when the result is taken
   logic [PROD_W+DIST_FRAC_BITS-1:0] shifted;
   logic [FINE_W-1:0]                fine_full;
   logic [22:0]                      fine_in, fine_ff;
   logic [14:0]                      whole_in, whole_ff;
   logic                             out_load;

   always_comb begin
      shifted   = (PROD_W + DIST_FRAC_BITS)'(prod_ff) << DIST_FRAC_BITS;
      fine_full = shifted[PROD_W+DIST_FRAC_BITS-1:Q];
      fine_in   = (64'(fine_full) > 64'(FINE_MAX)) ? FINE_MAX : 23'(fine_full);
      whole_in  = 15'(fine_full >> DIST_FRAC_BITS);
   end

   assign out_load = !out_vld_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         fine_ff  <= fine_in;
         whole_ff <= whole_in;
      end
   end

   assign rsp_ch.valid             = out_vld_ff;
   assign rsp_ch.distance_fine     = fine_ff;
   assign rsp_ch.distance_whole_km = whole_ff;

   // an accepted pair enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted pair missing from first stage");

   // a finished item is never dropped at the pipeline end
   a_drain: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_LAT-1] && out_load |=> out_vld_ff)
      else $error("finished item lost before output register");

   // whole km agrees with the fine distance unless saturated
   a_whole: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && fine_ff != FINE_MAX |->
         whole_ff == 15'(fine_ff >> DIST_FRAC_BITS))
      else $error("whole km does not match fine distance");

   // no distance beyond half the circumference
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> whole_ff <= MAX_KM)
      else $error("distance beyond half circumference");

endmodule
`default_nettype wire

// ----- sim/haversine_distance_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module haversine_distance_checker (
   input  wire          clock,
   input  wire          reset,
   hvd_req_if.sink      req_mon,
   hvd_rsp_if.sink      rsp_mon,
   output int           fail_count,
   output int           pending_count
);

   localparam int ANG_FRAC = 22;
   localparam int DIST_FRAC = 8;
   localparam longint ONE = 64'sd1 << 30;
   localparam longint unsigned PIH32 = 64'd6746518852;
   localparam longint unsigned PIH30 = 64'd1686629713;

   typedef struct packed {
      logic [22:0] fine;
      logic [14:0] whole;
   } dist_type;

   dist_type distance_queue[$];
   longint unsigned sin_dv [6] = '{156, 110, 72, 42, 20, 6};
   longint unsigned cos_dv [6] = '{182, 132, 90, 56, 30, 12};

   assign pending_count = distance_queue.size();

   // degrees fixed point to binary angle, truncating division
   function automatic logic [31:0] deg_to_bam(input longint d, input int shift);
      longint p;
      p = d * (64'sd1 << shift);
      return 32'(p / 360);
   endfunction

   // Taylor sine and cosine with quadrant fold
   function automatic void trig(input logic [31:0] bam, output longint s_o,
                                output longint c_o);
      longint unsigned r, x, x2, t;
      longint s, c;
      r = bam & 32'h3FFF_FFFF;
      x = (r * PIH32 + (64'd1 << 31)) >> 32;
      x2 = (x * x) >> 30;
      t = ONE;
      for (int i = 0; i < 6; i++) t = ONE - ((x2 * t) >> 30) / sin_dv[i];
      s = longint'((x * t) >> 30);
      t = ONE;
      for (int i = 0; i < 6; i++) t = ONE - ((x2 * t) >> 30) / cos_dv[i];
      c = ONE - longint'(((x2 * t) >> 30) / 2);
      if (c < 0) c = 0;
      case (bam[31:30])
         2'd0: begin s_o = s;  c_o = c;  end
         2'd1: begin s_o = c;  c_o = -s; end
         2'd2: begin s_o = -s; c_o = -c; end
         default: begin s_o = -c; c_o = s; end
      endcase
   endfunction

   // Q30 product, magnitude truncated
   function automatic longint qmul(input longint a, input longint b);
      longint unsigned ma, mb;
      longint p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = longint'((ma * mb) >> 30);
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned arcsine(input longint unsigned s);
      longint unsigned x2, p, sum;
      x2 = (s * s) >> 30;
      p = s;
      sum = 0;
      for (longint unsigned n = 0; n < 24; n++) begin
         sum += p / (2 * n + 1);
         p = ((p * x2) >> 30) * (2 * n + 1) / (2 * n + 2);
      end
      return sum;
   endfunction

   function automatic dist_type predict_distance(input logic signed [29:0] la,
                                                  input logic signed [30:0] oa,
                                                  input logic signed [29:0] lb,
                                                  input logic signed [30:0] ob);
      longint u, v, c1, c2, scrap, a, cc;
      longint unsigned h, fine;
      dist_type r;
      trig(deg_to_bam(longint'(lb) - longint'(la), 31 - ANG_FRAC), u, scrap);
      trig(deg_to_bam(longint'(ob) - longint'(oa), 31 - ANG_FRAC), v, scrap);
      trig(deg_to_bam(longint'(la), 32 - ANG_FRAC), scrap, c1);
      trig(deg_to_bam(longint'(lb), 32 - ANG_FRAC), scrap, c2);
      cc = qmul(c1, c2);
      a = qmul(u, u) + qmul(cc, qmul(v, v));
      if (a < 0) a = 0;
      if (a > ONE) a = ONE;
      if (a <= ONE / 2) h = arcsine(root_floor(longint'(a) << 30));
      else h = PIH30 - arcsine(root_floor(longint'(ONE - a) << 30));
      fine = ((h * 12742) << DIST_FRAC) >> 30;
      r.fine = fine > 64'h7F_FFFF ? 23'h7F_FFFF : 23'(fine);
      r.whole = 15'(fine >> DIST_FRAC);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   // watch both channels at each edge
   always @(posedge clock) begin
      dist_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            distance_queue.insert(distance_queue.size(),
                                  predict_distance(req_mon.lat_a, req_mon.lon_a,
                                                   req_mon.lat_b, req_mon.lon_b));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (distance_queue.size() == 0) begin
               report_mismatch("unexpected transfer", 0, 0);
            end else begin
               want = distance_queue.pop_front();
               if (rsp_mon.distance_fine !== want.fine)
                  report_mismatch("distance_fine", rsp_mon.distance_fine, want.fine);
               if (rsp_mon.distance_whole_km !== want.whole)
                  report_mismatch("distance_whole_km", rsp_mon.distance_whole_km,
                                  want.whole);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- sim/haversine_distance_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module haversine_distance_tb;

   localparam int LAT_MAX = 377487360;
   localparam int LON_MAX = 754974720;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;

   hvd_req_if req_ch ();
   hvd_rsp_if rsp_ch ();

   haversine_distance u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   haversine_distance_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.sink),
      .rsp_mon       (rsp_ch.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one, sometimes none for a stretch
   function automatic int gap_len(input bit burst);
      if (burst) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
      return $urandom_range(0, 3);
   endfunction

   function automatic int pick_coord(input int lim);
      case ($urandom_range(0, 9))
         0: return lim;
         1: return -lim;
         2: return 0;
         3: return int'($urandom_range(0, 40)) - 20;
         default: return int'($urandom_range(0, 2 * lim)) - lim;
      endcase
   endfunction

   // one pair, held until the transfer completes
   task automatic send_pair(input int la, input int oa, input int lb, input int ob,
                            input bit burst);
      int gap;
      gap = gap_len(burst);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.lat_a <= 30'(la);
      req_ch.lon_a <= 31'(oa);
      req_ch.lat_b <= 30'(lb);
      req_ch.lon_b <= 31'(ob);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // receiver stalls
   initial begin
      int gap;
      bit burst;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         burst = ($urandom_range(0, 7) == 0);
         repeat ($urandom_range(5, 60)) begin
            gap = gap_len(burst);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      bit burst;
      int lat_n;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.lat_a = '0;
      req_ch.lon_a = '0;
      req_ch.lat_b = '0;
      req_ch.lon_b = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, identical points, antipodes, poles, wrap, all bits
      send_pair(0, 0, 0, 0, 0);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
      send_pair(0, 0, 0, LON_MAX, 0);
      send_pair(0, -LON_MAX, 0, LON_MAX, 0);
      send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 0);
      send_pair(-LAT_MAX, 123, -LAT_MAX, -LON_MAX, 0);
      send_pair(1, 0, 0, 0, 0);
      send_pair(0, 1, 0, 0, 0);
      send_pair(0, 0, 0, LON_MAX / 2, 0);
      send_pair(LAT_MAX / 2, 0, -LAT_MAX / 2, LON_MAX, 0);
      send_pair(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1, 0);
      send_pair((1 << 29) - 1, (1 << 30) - 1, -(1 << 29), -(1 << 30), 0);
      send_pair(-1, -1, -1, -1, 0);
      send_pair(12345678, 98765432, 12345679, 98765433, 0);
      send_pair(0, 0, 0, LON_MAX - 1, 0);

      // random: mostly legal coordinates, some using the full field width
      for (int i = 0; i < 1350; i++) begin
         if (i % 40 == 0) burst = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0)
            send_pair(int'($urandom) >>> 2, int'($urandom) >>> 1,
                      int'($urandom) >>> 2, int'($urandom) >>> 1, burst);
         else begin
            lat_n = pick_coord(LAT_MAX);
            send_pair(lat_n, pick_coord(LON_MAX),
                      ($urandom_range(0, 5) == 0) ? -lat_n : pick_coord(LAT_MAX),
                      pick_coord(LON_MAX), burst);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
